[hw/rtl/pfb_pkg.sv]
// Shared types and constants of the page frame buffer bitmap blitter.
// No dependencies; used by pfb_engine and page_framebuffer_bitmap_blit.
package pfb_pkg;

   // request kinds, carried on tuser
   localparam logic [2:0] KIND_START = 3'd0;
   localparam logic [2:0] KIND_BLIT  = 3'd1;
   localparam logic [2:0] KIND_SET   = 3'd2;
   localparam logic [2:0] KIND_CLR   = 3'd3;
   localparam logic [2:0] KIND_WIPE  = 3'd4;
   localparam logic [2:0] KIND_READ  = 3'd5;

   // result status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_CLIP   = 2'd1;
   localparam logic [1:0] STAT_RANGE  = 2'd2;
   localparam logic [1:0] STAT_IGNORE = 2'd3;

   // configuration register indexes
   localparam logic [2:0] CSR_IMAGE_LEFT   = 3'd0;
   localparam logic [2:0] CSR_IMAGE_BOTTOM = 3'd1;
   localparam logic [2:0] CSR_IMAGE_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_IMAGE_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_GRAY_THRESH  = 3'd4;

   localparam logic [3:0] MAX_THRESHOLD = 4'd14;

   typedef struct packed {
      logic [6:0] img_left;
      logic [7:0] img_bottom;
      logic [7:0] img_width;
      logic [7:0] img_height;
      logic [3:0] gray_thr;
   } cfg_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] pixel_pair;
      logic [5:0] pixel_row;
      logic [6:0] pixel_column;
      logic [8:0] read_address;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [1:0] status;
      logic       blit_done;
   } rsp_type;

   // a gray pixel is on when above the threshold, clamped to 14
   function automatic logic pixel_on(input logic [3:0] level, input logic [3:0] thr);
      logic [3:0] t;
      t = (thr > MAX_THRESHOLD) ? MAX_THRESHOLD : thr;
      return level > t;
   endfunction

endpackage

[hw/rtl/pfb_store.sv]
// Single-port frame store memory, one byte per entry, registered read.
// No dependencies.
module pfb_store #(
   parameter int DEPTH = 504,
   parameter int AW    = 9
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wdata,
   output logic [7:0]    rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/pfb_engine.sv]
// Request sequencer: read-modify-write of the frame store, blit walk state,
// clearing pass. Depends on pfb_pkg; drives the port of pfb_store.
module pfb_engine #(
   parameter int SCREEN_WIDTH  = 84,
   parameter int SCREEN_HEIGHT = 48,
   localparam int STORE_BYTES  = SCREEN_WIDTH * (SCREEN_HEIGHT / 8),
   localparam int AW           = $clog2(STORE_BYTES)
) (
   input  logic             clock,
   input  logic             reset,
   input  pfb_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  pfb_pkg::req_type req,
   output logic             res_valid,
   input  logic             res_ready,
   output pfb_pkg::rsp_type res,
   output logic             mem_we,
   output logic [AW-1:0]    mem_addr,
   output logic [7:0]       mem_wdata,
   input  logic [7:0]       mem_rdata
);

   localparam int PAGES   = SCREEN_HEIGHT / 8;
   localparam int PG_TOP  = (PAGES - 1 > 7) ? PAGES - 1 : 7;
   localparam int PGW     = $clog2(PG_TOP + 1);
   localparam int IDX_MAX = 127 + SCREEN_WIDTH * PG_TOP + 256;
   localparam int IDXW    = $clog2(IDX_MAX + 1);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_RD_B, S_WR_A, S_WR_B, S_PX_WR, S_RD_RET, S_EMIT
   } state_type;

   state_type        state_ff,  state_in;
   logic [AW-1:0]    clr_cnt_ff, clr_cnt_in;
   logic             clr_rsp_ff, clr_rsp_in;
   logic [IDXW-1:0]  idx_ff,    idx_in;
   logic [PGW-1:0]   page_ff,   page_in;
   logic [2:0]       bit_ff,    bit_in;
   logic [6:0]       pairs_ff,  pairs_in;
   logic [1:0]       pad_ff,    pad_in;
   logic [7:0]       rows_ff,   rows_in;
   logic             active_ff, active_in;

   logic [7:0]       pair_ff,   pair_in;
   logic [7:0]       byte_ff,   byte_in;
   logic [AW-1:0]    pxa_ff,    pxa_in;
   logic [7:0]       pmask_ff,  pmask_in;
   logic             pset_ff,   pset_in;
   pfb_pkg::rsp_type res_ff,    res_in;

   logic             reject;
   logic [PGW-1:0]   page_start, page_nx;
   logic [2:0]       bit_nx;
   logic [7:0]       rows_dec;
   logic [7:0]       bmask;
   logic [IDXW-1:0]  idx_b, px_idx;
   logic             a_in_range, b_in_range;

   always_comb begin
      reject = (cfg.img_height == 8'd0) || cfg.img_width[0] ||
               (9'(cfg.img_left) + 9'(cfg.img_width) > 9'(SCREEN_WIDTH)) ||
               (9'(cfg.img_bottom) + 9'd1 < 9'(cfg.img_height)) ||
               (cfg.img_bottom > 8'(SCREEN_HEIGHT - 1));
      page_start = PGW'(cfg.img_bottom >> 3);
      bmask      = 8'd1 << bit_ff;
      idx_b      = idx_ff + IDXW'(1);
      a_in_range = idx_ff < IDXW'(STORE_BYTES);
      b_in_range = idx_b  < IDXW'(STORE_BYTES);
      px_idx     = IDXW'(SCREEN_WIDTH * int'(req.pixel_row[5:3])) + IDXW'(req.pixel_column);
      // step one row up the screen
      if (bit_ff != 3'd0) begin
         bit_nx  = bit_ff - 3'd1;
         page_nx = page_ff;
      end else begin
         bit_nx  = 3'd7;
         page_nx = (page_ff == '0) ? PGW'(7) : page_ff - PGW'(1);
      end
      rows_dec = (rows_ff != 8'd0) ? rows_ff - 8'd1 : 8'd0;
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      clr_rsp_in = clr_rsp_ff;
      idx_in     = idx_ff;
      page_in    = page_ff;
      bit_in     = bit_ff;
      pairs_in   = pairs_ff;
      pad_in     = pad_ff;
      rows_in    = rows_ff;
      active_in  = active_ff;
      pair_in    = pair_ff;
      byte_in    = byte_ff;
      pxa_in     = pxa_ff;
      pmask_in   = pmask_ff;
      pset_in    = pset_ff;
      res_in     = res_ff;
      mem_we     = 1'b0;
      mem_addr   = idx_ff[AW-1:0];
      mem_wdata  = 8'd0;

      case (state_ff)
         S_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_cnt_ff;
            if (clr_cnt_ff == AW'(STORE_BYTES - 1)) begin
               clr_cnt_in = '0;
               clr_rsp_in = 1'b0;
               res_in     = '{read_data: 8'd0, status: pfb_pkg::STAT_OK, blit_done: 1'b0};
               state_in   = clr_rsp_ff ? S_EMIT : S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               res_in   = '{read_data: 8'd0, status: pfb_pkg::STAT_OK, blit_done: 1'b0};
               pair_in  = req.pixel_pair;
               state_in = S_EMIT;
               case (req.kind)
                  pfb_pkg::KIND_START: begin
                     active_in = 1'b0;
                     if (reject) begin
                        res_in.status = pfb_pkg::STAT_CLIP;
                     end else begin
                        page_in   = page_start;
                        bit_in    = cfg.img_bottom[2:0];
                        rows_in   = cfg.img_height;
                        idx_in    = IDXW'(cfg.img_left) +
                                    IDXW'(SCREEN_WIDTH * int'(page_start));
                        pairs_in  = cfg.img_width[7:1];
                        pad_in    = 2'd0;
                        active_in = cfg.img_width != 8'd0;
                     end
                  end
                  pfb_pkg::KIND_BLIT: begin
                     if (!active_ff) begin
                        res_in.status = pfb_pkg::STAT_IGNORE;
                     end else if (pad_ff != 2'd0) begin
                        pad_in        = pad_ff - 2'd1;
                        res_in.status = pfb_pkg::STAT_IGNORE;
                     end else begin
                        // read left byte now
                        mem_addr = idx_ff[AW-1:0];
                        state_in = S_RD_B;
                     end
                  end
                  pfb_pkg::KIND_SET, pfb_pkg::KIND_CLR: begin
                     if (({3'd0, req.pixel_row} >= 9'(SCREEN_HEIGHT)) ||
                         ({2'd0, req.pixel_column} >= 9'(SCREEN_WIDTH))) begin
                        res_in.status = pfb_pkg::STAT_RANGE;
                     end else begin
                        mem_addr = px_idx[AW-1:0];
                        pxa_in   = px_idx[AW-1:0];
                        pmask_in = 8'd1 << req.pixel_row[2:0];
                        pset_in  = req.kind == pfb_pkg::KIND_SET;
                        state_in = S_PX_WR;
                     end
                  end
                  pfb_pkg::KIND_WIPE: begin
                     clr_cnt_in = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLEAR;
                  end
                  pfb_pkg::KIND_READ: begin
                     if (IDXW'(req.read_address) >= IDXW'(STORE_BYTES)) begin
                        res_in.status = pfb_pkg::STAT_RANGE;
                     end else begin
                        mem_addr = req.read_address[AW-1:0];
                        state_in = S_RD_RET;
                     end
                  end
                  default: begin
                     res_in.status = pfb_pkg::STAT_RANGE;
                  end
               endcase
            end
         end
         S_RD_B: begin
            byte_in  = mem_rdata;
            mem_addr = idx_b[AW-1:0];
            state_in = S_WR_A;
         end
         S_WR_A: begin
            mem_we    = a_in_range;
            mem_addr  = idx_ff[AW-1:0];
            mem_wdata = pfb_pkg::pixel_on(pair_ff[7:4], cfg.gray_thr) ?
                        (byte_ff | bmask) : (byte_ff & ~bmask);
            byte_in   = mem_rdata;
            state_in  = S_WR_B;
         end
         S_WR_B: begin
            mem_we    = b_in_range;
            mem_addr  = idx_b[AW-1:0];
            mem_wdata = pfb_pkg::pixel_on(pair_ff[3:0], cfg.gray_thr) ?
                        (byte_ff | bmask) : (byte_ff & ~bmask);
            res_in    = '{read_data: 8'd0, status: pfb_pkg::STAT_OK, blit_done: 1'b0};
            idx_in    = idx_ff + IDXW'(2);
            if (pairs_ff > 7'd1) begin
               pairs_in = pairs_ff - 7'd1;
            end else begin
               bit_in  = bit_nx;
               page_in = page_nx;
               rows_in = rows_dec;
               if (rows_dec == 8'd0) begin
                  pairs_in         = 7'd0;
                  active_in        = 1'b0;
                  res_in.blit_done = 1'b1;
               end else begin
                  // next row starts at the live left edge and width
                  idx_in   = IDXW'(cfg.img_left) + IDXW'(SCREEN_WIDTH * int'(page_nx));
                  pairs_in = cfg.img_width[7:1];
                  pad_in   = 2'd0 - cfg.img_width[2:1];
               end
            end
            state_in = S_EMIT;
         end
         S_PX_WR: begin
            mem_we    = 1'b1;
            mem_addr  = pxa_ff;
            mem_wdata = pset_ff ? (mem_rdata | pmask_ff) : (mem_rdata & ~pmask_ff);
            res_in    = '{read_data: 8'd0, status: pfb_pkg::STAT_OK, blit_done: 1'b0};
            state_in  = S_EMIT;
         end
         S_RD_RET: begin
            res_in   = '{read_data: mem_rdata, status: pfb_pkg::STAT_OK, blit_done: 1'b0};
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pair_ff  <= pair_in;
      byte_ff  <= byte_in;
      pxa_ff   <= pxa_in;
      pmask_ff <= pmask_in;
      pset_ff  <= pset_in;
      res_ff   <= res_in;
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_cnt_ff <= '0;
         clr_rsp_ff <= 1'b0;
         active_ff  <= 1'b0;
         idx_ff     <= '0;
         page_ff    <= '0;
         bit_ff     <= 3'd0;
         pairs_ff   <= 7'd0;
         pad_ff     <= 2'd0;
         rows_ff    <= 8'd0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         clr_rsp_ff <= clr_rsp_in;
         active_ff  <= active_in;
         idx_ff     <= idx_in;
         page_ff    <= page_in;
         bit_ff     <= bit_in;
         pairs_ff   <= pairs_in;
         pad_ff     <= pad_in;
         rows_ff    <= rows_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign res_valid = state_ff == S_EMIT;
   assign res       = res_ff;

endmodule

[hw/rtl/page_framebuffer_bitmap_blit.sv]
// Top level of the page frame buffer bitmap blitter: configuration
// registers, result output register. Depends on pfb_pkg, pfb_store, pfb_engine.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+----------------------------------------------
//  req     | in  | req_tvalid/tready    | tuser kind; tdata pair, row, column, address
//  rsp     | out | rsp_tvalid/tready    | tdata read_data, status; tlast blit_done
//  csr     | in  | csr_we               | csr_index, csr_wdata (no read-back)
//
// Items are taken one at a time: the next is accepted only once the engine has handed
// on the last result. A blit byte takes two read-modify-writes through the single-port
// store, and the clear store walk writes one byte a cycle.
// After reset a clearing pass runs with req_tready low; configuration writes are taken
// at any time. A waiting result stalls only the engine's hand-off of a further result:
// one more item is still accepted while rsp holds a result.
module page_framebuffer_bitmap_blit #(
   parameter int SCREEN_WIDTH  = 84,
   parameter int SCREEN_HEIGHT = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // pixel_pair[7:0], pixel_row[13:8],
                                   // pixel_column[20:14], read_address[29:21]
   input  logic [2:0]  req_tuser,  // kind[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // read_data[7:0], status[9:8]
   output logic        rsp_tlast,  // blit_done
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int STORE_BYTES = SCREEN_WIDTH * (SCREEN_HEIGHT / 8);
   localparam int AW          = $clog2(STORE_BYTES);

   pfb_pkg::cfg_type cfg_ff, cfg_in;
   pfb_pkg::req_type req;
   pfb_pkg::rsp_type res, out_ff, out_in;
   logic             out_valid_ff, out_valid_in;
   logic             res_valid, res_ready;
   logic             mem_we;
   logic [AW-1:0]    mem_addr;
   logic [7:0]       mem_wdata, mem_rdata;

   // unpack the request item
   assign req = '{kind:         req_tuser,
                  pixel_pair:   req_tdata[7:0],
                  pixel_row:    req_tdata[13:8],
                  pixel_column: req_tdata[20:14],
                  read_address: req_tdata[29:21]};

   // configuration writes: take each register from the low bits of the data
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            pfb_pkg::CSR_IMAGE_LEFT:   cfg_in.img_left   = csr_wdata[6:0];
            pfb_pkg::CSR_IMAGE_BOTTOM: cfg_in.img_bottom = csr_wdata;
            pfb_pkg::CSR_IMAGE_WIDTH:  cfg_in.img_width  = csr_wdata;
            pfb_pkg::CSR_IMAGE_HEIGHT: cfg_in.img_height = csr_wdata;
            pfb_pkg::CSR_GRAY_THRESH:  cfg_in.gray_thr   = csr_wdata[3:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // output register: load when empty or draining
   assign res_ready = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (reset) begin
         cfg_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         out_valid_ff <= out_valid_in;
      end
   end

   pfb_engine #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   pfb_store #(
      .DEPTH (STORE_BYTES),
      .AW    (AW)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff.status, out_ff.read_data};
   assign rsp_tlast  = out_ff.blit_done;

endmodule
